// ===== rtl/tcpq_pkg.sv =====
// Shared types, codes and constants for the two-class priority queue.
// No dependencies; tcpq_if, tcpq_queue, tcpq_hist and the core use this package.
`default_nettype none

package tcpq_pkg;

  localparam int unsigned ID_W              = 16;
  localparam int unsigned TICKET_W          = 16;
  localparam int unsigned CFG_W             = 4;
  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned HISTORY_DEPTH_DEF = 32;
  localparam int unsigned LIST_LIMIT_MAX    = 8;
  localparam int unsigned LIST_IDX_W        = $clog2(LIST_LIMIT_MAX);
  localparam logic [CFG_W-1:0] LIST_LIMIT_RESET = CFG_W'(5);

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_CALL = 2'd1,
    OP_LIST = 2'd2,
    OP_PEEK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_e;

  // waiting entry
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TICKET_W-1:0] ticket;
  } qentry_t;

  // served entry
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [TICKET_W-1:0] ticket;
    logic                cls;
  } hentry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     served_id;
    logic [TICKET_W-1:0] ticket;
    logic                served_class;
    logic                last;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tcpq_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// Depends on tcpq_pkg for field widths.
`default_nettype none

interface tcpq_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic                          priority_class;
  logic [tcpq_pkg::ID_W-1:0]     patient_id;

  modport source (output valid, operation, priority_class, patient_id, input ready);
  modport sink   (input valid, operation, priority_class, patient_id, output ready);
endinterface

interface tcpq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [tcpq_pkg::ID_W-1:0]     served_id;
  logic [tcpq_pkg::TICKET_W-1:0] ticket;
  logic                          served_class;
  logic                          last;

  modport source (output valid, status, served_id, ticket, served_class, last, input ready);
  modport sink   (input valid, status, served_id, ticket, served_class, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcpq_cell.sv =====
// One storage cell of a chain: loads a new word or takes its neighbor's word.
// Depends on nothing but the clock; used by tcpq_queue and tcpq_hist.
`default_nettype none

module tcpq_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         load_i,
  input  wire logic         shift_i,
  input  wire logic [W-1:0] load_data_i,
  input  wire logic [W-1:0] shift_data_i,
  output logic      [W-1:0] data_o
);

  logic [W-1:0] data_d, data_q;

  always_comb begin
    priority if (shift_i) begin
      data_d = shift_data_i;
    end else if (load_i) begin
      data_d = load_data_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/tcpq_queue.sv =====
// FIFO built as a chain of cells: head in cell 0, pop shifts toward the head.
// Depends on tcpq_pkg and tcpq_cell.
`default_nettype none

module tcpq_queue #(
  parameter int unsigned DEPTH = tcpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tcpq_pkg::queue_ctrl_t ctrl_i,
  input  wire tcpq_pkg::qentry_t     wdata_i,
  output tcpq_pkg::qentry_t          head_o,
  output logic                       empty_o,
  output logic                       full_o
);
  import tcpq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = $bits(qentry_t);

  logic [CW-1:0] count_d, count_q;
  logic [EW-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] nb_data;
    if (i == DEPTH - 1) begin : g_tail
      assign nb_data = '0;
    end else begin : g_mid
      assign nb_data = cell_data[i+1];
    end

    tcpq_cell #(.W(EW)) u_cell (
      .clk_i       (clk_i),
      .load_i      (ctrl_i.push && (count_q == CW'(i))),
      .shift_i     (ctrl_i.pop),
      .load_data_i (wdata_i),
      .shift_data_i(nb_data),
      .data_o      (cell_data[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.push) begin
      count_d = count_q + CW'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = qentry_t'(cell_data[0]);
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));

endmodule

`default_nettype wire

// ===== rtl/tcpq_hist.sv =====
// History stack as a chain of cells: a push shifts every entry one cell older,
// the newest sits in cell 0. Depends on tcpq_pkg and tcpq_cell.
`default_nettype none

module tcpq_hist #(
  parameter int unsigned DEPTH = tcpq_pkg::HISTORY_DEPTH_DEF,
  localparam int unsigned HCW  = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tcpq_pkg::hentry_t wdata_i,
  output logic [HCW-1:0]         count_o,
  output tcpq_pkg::hentry_t      view_o [tcpq_pkg::LIST_LIMIT_MAX]
);
  import tcpq_pkg::*;

  localparam int unsigned EW = $bits(hentry_t);

  logic [HCW-1:0] count_d, count_q;
  logic [EW-1:0]  cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] nb_data;
    if (i == 0) begin : g_top
      assign nb_data = wdata_i;
    end else begin : g_rest
      assign nb_data = cell_data[i-1];
    end

    tcpq_cell #(.W(EW)) u_cell (
      .clk_i       (clk_i),
      .load_i      (1'b0),
      .shift_i     (push_i),
      .load_data_i (nb_data),
      .shift_data_i(nb_data),
      .data_o      (cell_data[i])
    );
  end

  // only the newest few cells are ever read
  for (genvar j = 0; j < LIST_LIMIT_MAX; j++) begin : g_view
    if (j < DEPTH) begin : g_live
      assign view_o[j] = hentry_t'(cell_data[j]);
    end else begin : g_none
      assign view_o[j] = '0;
    end
  end

  // saturates at DEPTH: the oldest entry falls off the end
  always_comb begin
    count_d = count_q;
    if (push_i && (count_q != HCW'(DEPTH))) begin
      count_d = count_q + HCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/two_class_priority_queue_with_history_core.sv =====
// Two-class strict-priority queue with served history. Depends on tcpq_pkg,
// tcpq_if, tcpq_queue, tcpq_hist and tcpq_cell.
// Timing: add, call next and peek give their single response in the cycle after
// the request is taken; one such request per cycle while responses are taken.
// List: the request sets up the range, then one entry per cycle from the first
// history cells while responses are taken; no new request until the last is sent.
// Reset: queues and history empty, both ticket counters at 1, list limit 5;
// cell contents are not reset.
`default_nettype none

module two_class_priority_queue_with_history_core #(
  parameter int unsigned QUEUE_DEPTH   = tcpq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HISTORY_DEPTH = tcpq_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tcpq_req_if.sink                         req_i,
  tcpq_rsp_if.source                       rsp_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tcpq_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import tcpq_pkg::*;

  localparam int unsigned HCW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LIMW = (HCW > CFG_W) ? HCW : CFG_W;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIST_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Storage chains
  // ---------------------------------------------------------------------------
  queue_ctrl_t   urg_ctrl, nrm_ctrl;
  qentry_t       q_wdata;
  qentry_t       urg_head, nrm_head;
  logic          urg_empty, urg_full, nrm_empty, nrm_full;
  logic          hist_push;
  hentry_t       hist_wdata;
  logic [HCW-1:0] hist_cnt;
  hentry_t       hist_view [LIST_LIMIT_MAX];

  tcpq_queue #(.DEPTH(QUEUE_DEPTH)) u_urg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (urg_ctrl),
    .wdata_i(q_wdata),
    .head_o (urg_head),
    .empty_o(urg_empty),
    .full_o (urg_full)
  );

  tcpq_queue #(.DEPTH(QUEUE_DEPTH)) u_nrm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (nrm_ctrl),
    .wdata_i(q_wdata),
    .head_o (nrm_head),
    .empty_o(nrm_empty),
    .full_o (nrm_full)
  );

  tcpq_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (hist_push),
    .wdata_i(hist_wdata),
    .count_o(hist_cnt),
    .view_o (hist_view)
  );

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e                state_d, state_q;
  logic [LIST_IDX_W-1:0] idx_d, idx_q;       // list entry being sent
  logic [LIST_IDX_W-1:0] lidx_d, lidx_q;     // index of the final list entry
  logic [TICKET_W-1:0]   urg_tkt_d, urg_tkt_q;
  logic [TICKET_W-1:0]   nrm_tkt_d, nrm_tkt_q;
  logic                  out_v_d, out_v_q;
  rsp_t                  out_d, out_q;

  logic                  acc;
  logic                  out_free;   // output register empty or draining now
  logic                  res_load;
  op_e                   op;
  logic                  add_full;
  logic [TICKET_W-1:0]   add_tkt;
  logic [CFG_W-1:0]      lim_c;
  logic [LIMW-1:0]       lim_x, cnt_x, n_x;

  assign op       = op_e'(req_i.operation);
  assign out_free = !out_v_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign acc      = req_i.valid && req_i.ready;

  assign add_full = req_i.priority_class ? urg_full : nrm_full;
  assign add_tkt  = req_i.priority_class ? urg_tkt_q : nrm_tkt_q;

  // limit of zero acts as one, anything above the maximum as the maximum
  always_comb begin
    priority if (limit_q == '0) begin
      lim_c = CFG_W'(1);
    end else if (limit_q > CFG_W'(LIST_LIMIT_MAX)) begin
      lim_c = CFG_W'(LIST_LIMIT_MAX);
    end else begin
      lim_c = limit_q;
    end
  end

  assign lim_x = LIMW'(lim_c);
  assign cnt_x = LIMW'(hist_cnt);
  assign n_x   = (cnt_x < lim_x) ? cnt_x : lim_x;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc && (op == OP_LIST) && (hist_cnt != '0)) begin
          state_d = S_LIST;
        end
      end
      S_LIST: begin
        if (out_free && (idx_q == lidx_q)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath controls and response
  always_comb begin
    urg_ctrl   = '0;
    nrm_ctrl   = '0;
    q_wdata    = '{id: req_i.patient_id, ticket: add_tkt};
    hist_push  = 1'b0;
    hist_wdata = '0;
    urg_tkt_d  = urg_tkt_q;
    nrm_tkt_d  = nrm_tkt_q;
    idx_d      = idx_q;
    lidx_d     = lidx_q;
    res_load   = 1'b0;
    out_d      = '{status: ST_EMPTY, served_id: '0, ticket: '0,
                   served_class: 1'b0, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (op)
            OP_ADD: begin
              res_load = 1'b1;
              if (add_full) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status       = ST_OK;
                out_d.served_id    = req_i.patient_id;
                out_d.ticket       = add_tkt;
                out_d.served_class = req_i.priority_class;
                if (req_i.priority_class) begin
                  urg_ctrl.push = 1'b1;
                  urg_tkt_d = (urg_tkt_q == '1) ? TICKET_W'(1) : urg_tkt_q + TICKET_W'(1);
                end else begin
                  nrm_ctrl.push = 1'b1;
                  nrm_tkt_d = (nrm_tkt_q == '1) ? TICKET_W'(1) : nrm_tkt_q + TICKET_W'(1);
                end
              end
            end
            OP_CALL: begin
              res_load = 1'b1;
              // urgent class always wins
              priority if (!urg_empty) begin
                urg_ctrl.pop = 1'b1;
                hist_push    = 1'b1;
                hist_wdata   = '{id: urg_head.id, ticket: urg_head.ticket, cls: 1'b1};
              end else if (!nrm_empty) begin
                nrm_ctrl.pop = 1'b1;
                hist_push    = 1'b1;
                hist_wdata   = '{id: nrm_head.id, ticket: nrm_head.ticket, cls: 1'b0};
              end else begin
                hist_push    = 1'b0;
              end
              if (hist_push) begin
                out_d.status       = ST_OK;
                out_d.served_id    = hist_wdata.id;
                out_d.ticket       = hist_wdata.ticket;
                out_d.served_class = hist_wdata.cls;
              end
            end
            OP_PEEK: begin
              res_load = 1'b1;
              if (hist_cnt != '0) begin
                out_d.status       = ST_OK;
                out_d.served_id    = hist_view[0].id;
                out_d.ticket       = hist_view[0].ticket;
                out_d.served_class = hist_view[0].cls;
              end
            end
            OP_LIST: begin
              // empty history answers at once; otherwise entries stream from S_LIST
              res_load = (hist_cnt == '0);
              idx_d    = '0;
              lidx_d   = LIST_IDX_W'(n_x - LIMW'(1));
            end
            default: res_load = 1'b0;
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          res_load           = 1'b1;
          out_d.status       = ST_OK;
          out_d.served_id    = hist_view[idx_q].id;
          out_d.ticket       = hist_view[idx_q].ticket;
          out_d.served_class = hist_view[idx_q].cls;
          out_d.last         = (idx_q == lidx_q);
          idx_d              = idx_q + LIST_IDX_W'(1);
        end
      end
      default: res_load = 1'b0;
    endcase
  end

  // Output register: holds a response until the sink takes it
  always_comb begin
    if (res_load) begin
      out_v_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      lidx_q    <= '0;
      urg_tkt_q <= TICKET_W'(1);
      nrm_tkt_q <= TICKET_W'(1);
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      lidx_q    <= lidx_d;
      urg_tkt_q <= urg_tkt_d;
      nrm_tkt_q <= nrm_tkt_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.served_id    = out_q.served_id;
  assign rsp_o.ticket       = out_q.ticket;
  assign rsp_o.served_class = out_q.served_class;
  assign rsp_o.last         = out_q.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (urg_ctrl.push |-> !urg_full) and (nrm_ctrl.push |-> !nrm_full))
    else $error("push into a full queue");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !rsp_o.ready) |-> !res_load)
    else $error("pending response overwritten");

  a_list_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST && res_load && out_d.last) |=> (state_q == S_IDLE))
    else $error("list did not end after its final entry");

  a_hist_from_call: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_push |-> (acc && op == OP_CALL && (urg_ctrl.pop || nrm_ctrl.pop)))
    else $error("history push without a served entry");

endmodule

`default_nettype wire
